/* rtl/hsvlc_pkg.sv */
// hsvlc_pkg: shared types, constants and microcode for the hsv light color controller
package hsvlc_pkg;

   localparam int unsigned LEVEL_MAX  = 100;
   localparam int unsigned HUE_TURN   = 360;
   localparam int unsigned HUE_SECTOR = 60;

   // reciprocal constants: x / 100 = (x * 5243) >> 19, x / 60 = (x * 17477) >> 20
   localparam logic [14:0] RECIP_100 = 15'd5243;
   localparam logic [14:0] RECIP_60  = 15'd17477;
   localparam logic [14:0] SCALE_255 = 15'd255;

   localparam int unsigned STEP_W    = 3;
   localparam logic [STEP_W-1:0] STEP_LAST = 3'd6;

   typedef enum logic [1:0] {
      CMD_POWER  = 2'd0,
      CMD_BRIGHT = 2'd1,
      CMD_HUE    = 2'd2,
      CMD_SAT    = 2'd3
   } cmd_type;

   // multiplier operand a
   typedef enum logic [1:0] {
      OPA_BRIGHT  = 2'd0,
      OPA_PROD    = 2'd1,
      OPA_PROD_HI = 2'd2,
      OPA_SPAN    = 2'd3
   } opa_type;

   // multiplier operand b
   typedef enum logic [2:0] {
      OPB_255     = 3'd0,
      OPB_DIV100  = 3'd1,
      OPB_SAT_INV = 3'd2,
      OPB_FRAC    = 3'd3,
      OPB_DIV60   = 3'd4
   } opb_type;

   typedef struct packed {
      opa_type           opa;
      opb_type           opb;
      logic              load_prod;
      logic              load_top;
      logic              load_bot;
      logic              jump_if_off;
      logic [STEP_W-1:0] jump_target;
      logic              finish;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      w = '{opa: OPA_PROD, opb: OPB_255, load_prod: 1'b0, load_top: 1'b0, load_bot: 1'b0,
            jump_if_off: 1'b0, jump_target: '0, finish: 1'b0};
      case (step)
         3'd0: begin
            // v * 255, skip straight to the output step when the lamp is off
            w.opa = OPA_BRIGHT;  w.opb = OPB_255;     w.load_prod = 1'b1;
            w.jump_if_off = 1'b1; w.jump_target = STEP_LAST;
         end
         3'd1: begin
            w.opa = OPA_PROD;    w.opb = OPB_DIV100;  w.load_prod = 1'b1;
         end
         3'd2: begin
            // latch rgb_max, start rgb_max * (100 - s)
            w.opa = OPA_PROD_HI; w.opb = OPB_SAT_INV; w.load_prod = 1'b1; w.load_top = 1'b1;
         end
         3'd3: begin
            w.opa = OPA_PROD;    w.opb = OPB_DIV100;  w.load_prod = 1'b1;
         end
         3'd4: begin
            // latch rgb_min, start (max - min) * frac
            w.opa = OPA_SPAN;    w.opb = OPB_FRAC;    w.load_prod = 1'b1; w.load_bot = 1'b1;
         end
         3'd5: begin
            w.opa = OPA_PROD;    w.opb = OPB_DIV60;   w.load_prod = 1'b1;
         end
         3'd6: begin
            w.finish = 1'b1;
         end
         default: begin
            w.finish = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

/* rtl/hsvlc_sequencer.sv */
// hsvlc_sequencer: step counter and microcode rom driving the datapath
module hsvlc_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     stall,
   input  logic                     power_on,
   output logic                     busy,
   output hsvlc_pkg::ctrl_word_type ctrl
);
   import hsvlc_pkg::*;

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   ctrl_word_type     word;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_comb begin
      word    = ucode_rom(step_ff);
      busy_in = busy_ff;
      step_in = step_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            step_in = '0;
         end
      end else if (word.finish) begin
         if (!stall) begin
            busy_in = 1'b0;
            step_in = '0;
         end
      end else if (word.jump_if_off && !power_on) begin
         step_in = word.jump_target;
      end else begin
         step_in = step_ff + 1'b1;
      end

      ctrl           = word;
      ctrl.load_prod = word.load_prod && busy_ff;
      ctrl.load_top  = word.load_top && busy_ff;
      ctrl.load_bot  = word.load_bot && busy_ff;
      ctrl.finish    = word.finish && busy_ff && !stall;
   end

   assign busy = busy_ff;

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff <= STEP_LAST)
      else $error("step counter past the last microcode step");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      busy_ff && word.finish && stall |=> busy_ff && step_ff == $past(step_ff))
      else $error("output step left while the result slot was full");

   a_off_skip: assert property (@(posedge clock) disable iff (reset)
      busy_ff && step_ff == 3'd0 && !power_on |=> step_ff == STEP_LAST)
      else $error("lamp off did not skip to the output step");

endmodule

/* rtl/hsvlc_datapath.sv */
// hsvlc_datapath: lamp settings, shared multiplier and rgb sector mapping
module hsvlc_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load_cmd,
   input  hsvlc_pkg::cmd_type       cmd,
   input  logic [8:0]               set_value,
   input  hsvlc_pkg::ctrl_word_type ctrl,
   output logic                     power_on,
   output logic [7:0]               red,
   output logic [7:0]               green,
   output logic [7:0]               blue,
   output logic                     lamp_on
);
   import hsvlc_pkg::*;

   logic       power_ff, power_in;
   logic [8:0] hue_ff, hue_in;
   logic [6:0] sat_ff, sat_in;
   logic [6:0] bright_ff, bright_in;
   logic [6:0] level_clamped;

   logic [27:0] prod_ff, prod_in;
   logic [7:0]  top_ff, bot_ff;
   logic [7:0]  red_ff, green_ff, blue_ff, red_in, green_in, blue_in;
   logic        lamp_ff, lamp_in;

   logic [8:0]  hue_mod;
   logic [2:0]  sector;
   logic [5:0]  frac;
   logic [14:0] opa, opb;
   logic [29:0] mult;
   logic [7:0]  prod_hi, span, adj, up, down;

   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff  <= 1'b0;
         hue_ff    <= '0;
         sat_ff    <= '0;
         bright_ff <= '0;
      end else begin
         power_ff  <= power_in;
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         bright_ff <= bright_in;
      end
   end

   always_comb begin
      level_clamped = (set_value > 9'(LEVEL_MAX)) ? 7'(LEVEL_MAX) : set_value[6:0];
      power_in  = power_ff;
      hue_in    = hue_ff;
      sat_in    = sat_ff;
      bright_in = bright_ff;
      if (load_cmd) begin
         case (cmd)
            CMD_POWER: begin
               power_in = set_value[0];
            end
            CMD_BRIGHT: begin
               bright_in = level_clamped;
               power_in  = 1'b1;
            end
            CMD_HUE: begin
               hue_in   = set_value;
               power_in = 1'b1;
            end
            CMD_SAT: begin
               sat_in   = level_clamped;
               power_in = 1'b1;
            end
            default: begin
               power_in = power_ff;
            end
         endcase
      end
   end

   // hue below 512, one subtraction reduces it modulo 360
   always_comb begin
      hue_mod = (hue_ff >= 9'(HUE_TURN)) ? hue_ff - 9'(HUE_TURN) : hue_ff;
      if (hue_mod >= 9'd300) begin
         sector = 3'd5; frac = 6'(hue_mod - 9'd300);
      end else if (hue_mod >= 9'd240) begin
         sector = 3'd4; frac = 6'(hue_mod - 9'd240);
      end else if (hue_mod >= 9'd180) begin
         sector = 3'd3; frac = 6'(hue_mod - 9'd180);
      end else if (hue_mod >= 9'd120) begin
         sector = 3'd2; frac = 6'(hue_mod - 9'd120);
      end else if (hue_mod >= 9'(HUE_SECTOR)) begin
         sector = 3'd1; frac = 6'(hue_mod - 9'(HUE_SECTOR));
      end else begin
         sector = 3'd0; frac = hue_mod[5:0];
      end
   end

   assign prod_hi = prod_ff[26:19];
   assign span    = top_ff - prod_hi;

   always_comb begin
      case (ctrl.opa)
         OPA_BRIGHT:  opa = {8'd0, bright_ff};
         OPA_PROD:    opa = prod_ff[14:0];
         OPA_PROD_HI: opa = {7'd0, prod_hi};
         OPA_SPAN:    opa = {7'd0, span};
         default:     opa = '0;
      endcase
      case (ctrl.opb)
         OPB_255:     opb = SCALE_255;
         OPB_DIV100:  opb = RECIP_100;
         OPB_SAT_INV: opb = 15'(7'(LEVEL_MAX) - sat_ff);
         OPB_FRAC:    opb = {9'd0, frac};
         OPB_DIV60:   opb = RECIP_60;
         default:     opb = '0;
      endcase
      mult    = opa * opb;
      prod_in = ctrl.load_prod ? mult[27:0] : prod_ff;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (ctrl.load_top) begin
         top_ff <= prod_hi;
      end
      if (ctrl.load_bot) begin
         bot_ff <= prod_hi;
      end
   end

   assign adj  = prod_ff[27:20];
   assign up   = bot_ff + adj;
   assign down = top_ff - adj;

   always_comb begin
      red_in   = '0;
      green_in = '0;
      blue_in  = '0;
      lamp_in  = power_ff;
      if (power_ff) begin
         case (sector)
            3'd0: begin red_in = top_ff; green_in = up;     blue_in = bot_ff; end
            3'd1: begin red_in = down;   green_in = top_ff; blue_in = bot_ff; end
            3'd2: begin red_in = bot_ff; green_in = top_ff; blue_in = up;     end
            3'd3: begin red_in = bot_ff; green_in = down;   blue_in = top_ff; end
            3'd4: begin red_in = up;     green_in = bot_ff; blue_in = top_ff; end
            default: begin red_in = top_ff; green_in = bot_ff; blue_in = down; end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         lamp_ff  <= lamp_in;
      end
   end

   assign power_on = power_ff;
   assign red      = red_ff;
   assign green    = green_ff;
   assign blue     = blue_ff;
   assign lamp_on  = lamp_ff;

   a_levels_clamped: assert property (@(posedge clock) disable iff (reset)
      sat_ff <= 7'(LEVEL_MAX) && bright_ff <= 7'(LEVEL_MAX))
      else $error("stored level above full scale");

   a_level_sets_power: assert property (@(posedge clock) disable iff (reset)
      load_cmd && cmd != CMD_POWER |=> power_ff)
      else $error("level command did not turn the lamp on");

   a_min_below_max: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish && power_ff |-> bot_ff <= top_ff)
      else $error("rgb_min above rgb_max");

endmodule

/* rtl/hsv_light_color_controller_unit.sv */
// hsv_light_color_controller_unit: top level of the hsv lamp color controller
//
// Each request sets one lamp setting and yields exactly one rgb response.
// Request channel: req_tuser carries the command (power, brightness, hue,
// saturation) and req_tdata[8:0] the new value; a request is taken when
// req_tvalid and req_tready are both high.
// Response channel: rsp_tdata carries red, green, blue and the lamp power
// flag; it is held in an output register until rsp_tready is seen.
// The conversion runs as a seven-step microprogram over one shared 15x15
// multiplier; divisions by 100 and 60 are reciprocal multiplies.
// With the lamp on a request runs every step of the microprogram before
// the response is written and the next request can be accepted; with the
// lamp off the program skips from its first step straight to its last.
// req_tready is low while the microprogram runs. If the previous response
// is still waiting, the last step holds until the output register frees.
// Reset turns the lamp off and clears hue, saturation and brightness to zero;
// no response is pending afterwards.
module hsv_light_color_controller_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [8:0] set_value, [15:9] zero
   input  logic [1:0]  req_tuser,  // [1:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // [7:0] red, [15:8] green, [23:16] blue, [24] lamp_on
);
   import hsvlc_pkg::*;

   logic          accept;
   logic          busy;
   logic          stall;
   logic          power_on;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   ctrl_word_type ctrl;
   logic [7:0]    red, green, blue;
   logic          lamp_on;

   assign req_tready = !busy;
   assign accept     = req_tvalid && !busy;
   assign stall      = rsp_tvalid_ff && !rsp_tready;

   hsvlc_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .stall    (stall),
      .power_on (power_on),
      .busy     (busy),
      .ctrl     (ctrl)
   );

   hsvlc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .load_cmd  (accept),
      .cmd       (cmd_type'(req_tuser)),
      .set_value (req_tdata[8:0]),
      .ctrl      (ctrl),
      .power_on  (power_on),
      .red       (red),
      .green     (green),
      .blue      (blue),
      .lamp_on   (lamp_on)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (ctrl.finish) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'd0, lamp_on, blue, green, red};

   a_off_is_black: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && !lamp_on |-> {red, green, blue} == 24'd0)
      else $error("lamp off but color not black");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy && !ctrl.finish)
      else $error("request accepted without starting the microprogram");

   a_finish_needs_busy: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |-> busy && !stall)
      else $error("response written outside a running program or over a held one");

endmodule

/* tb/testbench.sv */
// testbench: random and directed command checks of the hsv light color controller
`timescale 1ns / 1ps

module testbench;
   import hsvlc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned REPORT_MAX  = 10;
   localparam int unsigned RANDOM_REQS = 600;
   localparam int unsigned DRAIN_WAIT  = 16;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       lamp_on;
   } lamp_color_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;  // [8:0] set_value, [15:9] zero
   logic [1:0]  req_tuser;  // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;  // [7:0] red, [15:8] green, [23:16] blue, [24] lamp_on

   // lamp settings as the block should hold them
   logic        lamp_power;
   logic [8:0]  hue_set;
   logic [6:0]  sat_set;
   logic [6:0]  bright_set;

   lamp_color_type pending_colors[$];
   int unsigned error_count;
   int unsigned cycle_count;
   int unsigned rsp_hold_cycles;

   hsv_light_color_controller_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic note_failure(input string msg);
      error_count++;
      if (error_count <= REPORT_MAX) $display("%s", msg);
   endtask

   // applies one command to the lamp settings and returns the color it produces
   function automatic lamp_color_type predict_lamp_color(input cmd_type c, input logic [8:0] v);
      lamp_color_type col;
      int unsigned h, top, bot, adj;
      col = '{red: 8'd0, green: 8'd0, blue: 8'd0, lamp_on: 1'b0};
      case (c)
         CMD_POWER: begin
            lamp_power = v[0];
         end
         CMD_BRIGHT: begin
            bright_set = (v > LEVEL_MAX) ? 7'(LEVEL_MAX) : v[6:0];
            lamp_power = 1'b1;
         end
         CMD_HUE: begin
            hue_set = v;
            lamp_power = 1'b1;
         end
         default: begin
            sat_set = (v > LEVEL_MAX) ? 7'(LEVEL_MAX) : v[6:0];
            lamp_power = 1'b1;
         end
      endcase
      col.lamp_on = lamp_power;
      if (lamp_power) begin
         h   = int'(hue_set) % HUE_TURN;
         top = int'(bright_set) * 255 / LEVEL_MAX;
         bot = top * (LEVEL_MAX - int'(sat_set)) / LEVEL_MAX;
         adj = (top - bot) * (h % HUE_SECTOR) / HUE_SECTOR;
         case (h / HUE_SECTOR)
            0: begin
               col.red = 8'(top);       col.green = 8'(bot + adj); col.blue = 8'(bot);
            end
            1: begin
               col.red = 8'(top - adj); col.green = 8'(top);       col.blue = 8'(bot);
            end
            2: begin
               col.red = 8'(bot);       col.green = 8'(top);       col.blue = 8'(bot + adj);
            end
            3: begin
               col.red = 8'(bot);       col.green = 8'(top - adj); col.blue = 8'(top);
            end
            4: begin
               col.red = 8'(bot + adj); col.green = 8'(bot);       col.blue = 8'(top);
            end
            default: begin
               col.red = 8'(top);       col.green = 8'(bot);       col.blue = 8'(top - adj);
            end
         endcase
      end
      return col;
   endfunction

   // offers one request, waits for it to be taken, then idles for gap cycles
   task automatic send_request(input cmd_type c, input logic [8:0] v, input int unsigned gap);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= {7'd0, v};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_colors.push_back(predict_lamp_color(c, v));
      if (gap != 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   function automatic logic [8:0] random_value();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return 9'($urandom_range(0, HUE_TURN));
      if (pick < 8) return 9'($urandom_range(0, 511));
      case ($urandom_range(0, 5))
         0: return 9'd0;
         1: return 9'(LEVEL_MAX);
         2: return 9'(LEVEL_MAX + 1);
         3: return 9'(HUE_TURN - 1);
         4: return 9'(HUE_TURN);
         default: return 9'h1FF;
      endcase
   endfunction

   function automatic cmd_type random_cmd();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 3) return CMD_POWER;
      if (r < 8) return CMD_BRIGHT;
      if (r < 14) return CMD_HUE;
      return CMD_SAT;
   endfunction

   // receiver: random stall modes per segment, plus an on-demand long hold
   initial begin : rsp_stall_pattern
      int unsigned mode, seg_left, hold_left, phase;
      logic ready_next;
      rsp_tready = 1'b0;
      seg_left = 0;
      hold_left = 0;
      phase = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles != 0) begin
            hold_left = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (seg_left == 0) begin
            mode = $urandom_range(0, 3);
            seg_left = $urandom_range(10, 150);
         end
         seg_left--;
         phase++;
         if (hold_left != 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            case (mode)
               0: ready_next = 1'b1;
               1: ready_next = ($urandom_range(0, 3) != 0);
               2: ready_next = ($urandom_range(0, 3) == 0);
               default: ready_next = ((phase % 5) < 2);
            endcase
         end
         rsp_tready <= ready_next;
      end
   end

   always @(posedge clock) begin : rsp_check
      lamp_color_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.red     = rsp_tdata[7:0];
         got.green   = rsp_tdata[15:8];
         got.blue    = rsp_tdata[23:16];
         got.lamp_on = rsp_tdata[24];
         if (pending_colors.size() == 0) begin
            note_failure($sformatf("unexpected response rgb=%0d,%0d,%0d on=%0b",
                                   got.red, got.green, got.blue, got.lamp_on));
         end else begin
            want = pending_colors.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.lamp_on !== want.lamp_on)
               note_failure($sformatf(
                  "color mismatch: want rgb=%0d,%0d,%0d on=%0b got rgb=%0d,%0d,%0d on=%0b",
                  want.red, want.green, want.blue, want.lamp_on,
                  got.red, got.green, got.blue, got.lamp_on));
         end
      end
   end

   task automatic test_power_control();
      send_request(CMD_POWER, 9'd1, 0);     // on from reset: all levels zero gives black
      send_request(CMD_POWER, 9'h1FE, 1);   // upper bits ignored, bit 0 clear turns off
      send_request(CMD_POWER, 9'h1FF, 0);
      send_request(CMD_POWER, 9'd0, 2);
   endtask

   task automatic test_level_extremes();
      send_request(CMD_BRIGHT, 9'h1FF, 0);  // turns lamp on, saturates to full
      send_request(CMD_SAT, 9'd100, 0);
      send_request(CMD_POWER, 9'd0, 1);
      send_request(CMD_POWER, 9'd1, 0);     // stored settings come back
      send_request(CMD_SAT, 9'd255, 3);
      send_request(CMD_SAT, 9'd0, 0);
      send_request(CMD_BRIGHT, 9'd0, 0);
      send_request(CMD_BRIGHT, 9'd1, 2);
      send_request(CMD_BRIGHT, 9'd101, 0);
   endtask

   task automatic test_hue_sectors();
      logic [8:0] hue_points[12] = '{9'd0, 9'd59, 9'd60, 9'd119, 9'd120, 9'd180,
                                      9'd240, 9'd300, 9'd359, 9'd360, 9'd419, 9'd511};
      send_request(CMD_SAT, 9'd70, 0);
      send_request(CMD_BRIGHT, 9'd90, 0);
      foreach (hue_points[i]) send_request(CMD_HUE, hue_points[i], $urandom_range(0, 3));
   endtask

   task automatic test_random_commands();
      int unsigned burst_left, gap_after;
      burst_left = 0;
      gap_after = 0;
      for (int unsigned n = 0; n < RANDOM_REQS; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_after = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         end
         burst_left--;
         send_request(random_cmd(), random_value(), (burst_left == 0) ? gap_after : 0);
      end
   endtask

   task automatic test_output_backpressure();
      @(posedge clock);
      rsp_hold_cycles = 400;
      for (int unsigned n = 0; n < 24; n++) send_request(random_cmd(), random_value(), 0);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_POWER;
      lamp_power = 1'b0;
      hue_set = '0;
      sat_set = '0;
      bright_set = '0;
      error_count = 0;
      cycle_count = 0;
      rsp_hold_cycles = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_power_control();
      test_level_extremes();
      test_hue_sectors();
      test_random_commands();
      test_output_backpressure();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
